/* src/tnpm_pkg.sv */
`default_nettype none
package tnpm_pkg;

  // Fixed field widths of the streams.
  localparam int unsigned VALUE_W      = 21;
  localparam int unsigned THR_W        = 20;
  localparam int unsigned IDX_W        = 2;
  localparam int unsigned PULSE_W      = 16;
  localparam int unsigned VALUE_FIELDS = 4;
  localparam int unsigned IN_TDATA_W   = 88;
  localparam int unsigned OUT_TDATA_W  = 24;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [PULSE_W-1:0] PULSE_ZERO_RST = 16'd36000;
  localparam logic [PULSE_W-1:0] PULSE_FULL_RST = 16'd14000;

  typedef enum logic {
    CMD_SET_ONE = 1'b0,
    CMD_SET_ALL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_ZERO = 1'b0,
    REG_PULSE_FULL = 1'b1
  } cfg_reg_e;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* src/throttle_normalizing_pwm_mixer.sv */
// Four-channel throttle mixer with normalization and pulse-width output.
// Input stream: s_axis_tuser selects set_one (one motor) or set_all; tdata
// carries the motor index and four signed throttles with FRAC_BITS fraction
// bits. A negative set_one, or one whose motor is out of range, is absorbed
// without results. Output stream: one transfer per reported motor with the
// motor number and the pulse width in timer ticks; tlast marks the final
// transfer of an item. The cfg channel writes the pulse widths at zero and
// full throttle; it is always ready and should only be used while idle.
// Sequence: an accept step, a scan of all MOTOR_COUNT throttles for the
// maximum, then per reported motor a prep step, a division in the shared
// serial divider when the maximum throttle is above 1.0, two multiply
// steps and an emit step. s_axis_tready is high only while idle.
// Results sit in an output register; a stalled receiver holds the block in
// its emit step, and the next item can be accepted while the final result
// still waits. Reset clears all throttles and loads the pulse registers
// with 36000 and 14000 ticks.
`default_nettype none
module throttle_normalizing_pwm_mixer
  import tnpm_pkg::*;
#(
  parameter int unsigned MOTOR_COUNT = 4,
  parameter int unsigned FRAC_BITS   = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // motor_index[1:0], value_0[22:2], value_1[43:23], value_2[64:44],
  // value_3[85:65], zero padding[87:86]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // out_motor[1:0], pulse_ticks[17:2], zero padding[23:18]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [PULSE_W-1:0]     cfg_data_i
);

  localparam int unsigned MIDX_W   = $clog2(MOTOR_COUNT);
  localparam int unsigned SW       = FRAC_BITS + 1;
  localparam int unsigned ACC_W    = FRAC_BITS + PULSE_W;
  localparam int unsigned PROD_W   = SW + PULSE_W;
  localparam int unsigned N_REPORT =
    (MOTOR_COUNT < VALUE_FIELDS) ? MOTOR_COUNT : VALUE_FIELDS;
  localparam logic [SW-1:0]     ONE_Q       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [MIDX_W-1:0] LAST_REPORT = MIDX_W'(N_REPORT - 1);
  localparam logic [MIDX_W-1:0] LAST_MOTOR  = MIDX_W'(MOTOR_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_MUL_ZERO,
    ST_MUL_FULL,
    ST_EMIT
  } state_e;

  state_e             st_q;
  logic [THR_W-1:0]   thr_q [MOTOR_COUNT];
  logic [THR_W-1:0]   max_q;
  logic [MIDX_W-1:0]  idx_q;
  logic [MIDX_W-1:0]  start_q;
  cmd_e               cmd_q;
  logic [SW-1:0]      scaled_q;
  logic [ACC_W-1:0]   acc_q;
  logic [PULSE_W-1:0] pz_q;
  logic [PULSE_W-1:0] pf_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_motor_q;
  logic [PULSE_W-1:0] out_pulse_q;
  logic               out_last_q;

  logic signed [VALUE_W-1:0] val [VALUE_FIELDS];
  logic [IDX_W-1:0]   in_motor;
  logic [MIDX_W-1:0]  in_sel;
  logic               motor_ok;
  logic               in_acc;
  logic               above_one;
  logic               div_start;
  div_stat_t          div_stat;
  logic [SW-1:0]      div_quot;
  logic [SW-1:0]      mul_a;
  logic [PULSE_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic               out_free;
  logic               is_last;

  always_comb begin
    for (int i = 0; i < VALUE_FIELDS; i++) begin
      val[i] = s_axis_tdata[IDX_W + i*VALUE_W +: VALUE_W];
    end
  end

  assign in_motor      = s_axis_tdata[IDX_W-1:0];
  assign in_sel        = MIDX_W'(in_motor);
  assign motor_ok      = 32'(in_motor) < MOTOR_COUNT;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign above_one = max_q > THR_W'(ONE_Q);
  assign div_start = (st_q == ST_PREP) && above_one;

  tnpm_div #(
    .QW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (thr_q[idx_q]),
    .divisor_i  (max_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // One multiplier serves both terms of the blend between the two widths.
  assign mul_a = (st_q == ST_MUL_ZERO) ? (ONE_Q - scaled_q) : scaled_q;
  assign mul_b = (st_q == ST_MUL_ZERO) ? pz_q : pf_q;
  assign prod  = mul_a * mul_b;

  assign out_free = !out_valid_q || m_axis_tready;
  assign is_last  = (cmd_q == CMD_SET_ONE) || (idx_q == LAST_REPORT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      pz_q        <= PULSE_ZERO_RST;
      pf_q        <= PULSE_FULL_RST;
      idx_q       <= '0;
      start_q     <= '0;
      max_q       <= '0;
      cmd_q       <= CMD_SET_ONE;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        thr_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_PULSE_ZERO: pz_q <= cfg_data_i;
          REG_PULSE_FULL: pf_q <= cfg_data_i;
          default: ;
        endcase
      end

      // The emit step refills the output register in the cycle it drains.
      if (out_valid_q && m_axis_tready && (st_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q <= '0;
            max_q <= '0;
            if (cmd_e'(s_axis_tuser) == CMD_SET_ONE) begin
              cmd_q <= CMD_SET_ONE;
              if (!val[0][VALUE_W-1] && motor_ok) begin
                thr_q[in_sel] <= val[0][THR_W-1:0];
                start_q       <= in_sel;
                st_q          <= ST_SCAN;
              end
            end else begin
              cmd_q   <= CMD_SET_ALL;
              start_q <= '0;
              st_q    <= ST_SCAN;
              for (int i = 0; i < N_REPORT; i++) begin
                if (!val[i][VALUE_W-1]) begin
                  thr_q[i] <= val[i][THR_W-1:0];
                end
              end
            end
          end
        end
        ST_SCAN: begin
          if (thr_q[idx_q] > max_q) begin
            max_q <= thr_q[idx_q];
          end
          if (idx_q == LAST_MOTOR) begin
            idx_q <= start_q;
            st_q  <= ST_PREP;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_PREP: begin
          if (above_one) begin
            st_q <= ST_DIV;
          end else begin
            scaled_q <= SW'(thr_q[idx_q]);
            st_q     <= ST_MUL_ZERO;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            scaled_q <= div_quot;
            st_q     <= ST_MUL_ZERO;
          end
        end
        ST_MUL_ZERO: begin
          acc_q <= ACC_W'(prod);
          st_q  <= ST_MUL_FULL;
        end
        ST_MUL_FULL: begin
          acc_q <= acc_q + ACC_W'(prod);
          st_q  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_motor_q <= IDX_W'(idx_q);
            out_pulse_q <= acc_q[FRAC_BITS +: PULSE_W];
            out_last_q  <= is_last;
            if (is_last) begin
              st_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q  <= ST_PREP;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - PULSE_W - IDX_W)'(0), out_pulse_q, out_motor_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while the sequencer is idle");

  a_max_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PREP) |-> (max_q >= thr_q[idx_q]))
    else $error("scanned maximum below a throttle");

  a_scaled_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL_ZERO) |-> (scaled_q <= ONE_Q))
    else $error("scaled throttle above 1.0");

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT && out_free) |=> m_axis_tvalid)
    else $error("result not presented after emit");
`endif

endmodule
`default_nettype wire

/* src/tnpm_div.sv */
`default_nettype none
module tnpm_div
  import tnpm_pkg::*;
#(
  parameter int unsigned QW = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [THR_W-1:0] dividend_i,
  input  wire logic [THR_W-1:0] divisor_i,
  output div_stat_t             stat_o,
  output logic      [QW-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [THR_W:0]   rem_q;
  logic [QW-1:0]    quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [THR_W-1:0] div_q;

  logic             ge;
  logic [THR_W:0]   rem_next;

  // The dividend never exceeds the divisor, so the first step already
  // weighs the integer bit of the quotient and the remainder stays below
  // the divisor after every subtraction.
  assign ge       = rem_q >= {1'b0, div_q};
  assign rem_next = ge ? (rem_q - {1'b0, div_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= {rem_next[THR_W-1:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule
`default_nettype wire

/* test/tb_throttle_normalizing_pwm_mixer.sv */
module tb_throttle_normalizing_pwm_mixer;
  import tnpm_pkg::*;

  localparam int unsigned FRAC           = 12;
  localparam int unsigned ONE_Q          = 1 << FRAC;
  localparam int unsigned SETTLE_CYCLES  = 120;
  localparam int unsigned RX_HOLD_CYCLES = 600;
  localparam int unsigned PHASE_ITEMS    = 58;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  idx;
    logic [20:0] v0;
    logic [20:0] v1;
    logic [20:0] v2;
    logic [20:0] v3;
  } mix_item_t;

  // Pulse widths are typed in only for rows that can be worked out by hand.
  typedef struct packed {
    mix_item_t        item;
    logic             typed;
    logic [3:0][15:0] want;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  motor;
    logic [15:0] ticks;
    logic        last;
  } pulse_rec_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [PULSE_W-1:0]     cfg_data_i    = '0;

  logic [19:0] throttle_q12 [4];
  logic [12:0] scaled_q12 [4];
  logic [15:0] ticks_at_zero;
  logic [15:0] ticks_at_full;
  pulse_rec_t  pending_pulses [$];

  logic        rx_hold_req     = 1'b0;
  int          burst_left      = 0;
  int          bad_results     = 0;
  int          results_seen    = 0;
  int          items_taken     = 0;
  int          set_all_count   = 0;
  int          ignored_count   = 0;
  int          settings_loaded = 0;
  int unsigned cycle_count     = 0;

  logic [15:0] zero_set [7] = '{16'd36000, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd14000};
  logic [15:0] full_set [7] = '{16'd14000, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd36000};
  dir_row_t    dir_rows [18];

  throttle_normalizing_pwm_mixer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] ticks_for(input logic [12:0] s);
    logic [63:0] num;
    num = (64'(ONE_Q) - 64'(s)) * 64'(ticks_at_zero) + 64'(s) * 64'(ticks_at_full);
    return num[FRAC+15:FRAC];
  endfunction

  // Throttles are divided by the largest one only when it is above 1.0.
  function automatic void renormalize();
    logic [19:0] peak;
    logic [63:0] quot;
    peak = '0;
    foreach (throttle_q12[m]) begin
      if (throttle_q12[m] > peak) peak = throttle_q12[m];
    end
    foreach (throttle_q12[m]) begin
      if (peak <= ONE_Q) begin
        scaled_q12[m] = throttle_q12[m][12:0];
      end else begin
        quot = (64'(throttle_q12[m]) << FRAC) / 64'(peak);
        scaled_q12[m] = quot[12:0];
      end
    end
  endfunction

  function automatic int mix_throttles(input mix_item_t it, output pulse_rec_t [3:0] recs);
    int n;
    n = 0;
    recs = '0;
    if (it.cmd == CMD_SET_ONE) begin
      if (!it.v0[20]) begin
        throttle_q12[it.idx] = it.v0[19:0];
        renormalize();
        recs[0].motor = it.idx;
        recs[0].ticks = ticks_for(scaled_q12[it.idx]);
        recs[0].last  = 1'b1;
        n = 1;
      end
    end else begin
      if (!it.v0[20]) throttle_q12[0] = it.v0[19:0];
      if (!it.v1[20]) throttle_q12[1] = it.v1[19:0];
      if (!it.v2[20]) throttle_q12[2] = it.v2[19:0];
      if (!it.v3[20]) throttle_q12[3] = it.v3[19:0];
      renormalize();
      for (int m = 0; m < 4; m++) begin
        recs[m].motor = 2'(m);
        recs[m].ticks = ticks_for(scaled_q12[m]);
        recs[m].last  = (m == 3);
      end
      n = 4;
    end
    return n;
  endfunction

  function automatic dir_row_t row(input cmd_e c, input logic [1:0] i,
                                   input logic [20:0] a, input logic [20:0] b,
                                   input logic [20:0] d, input logic [20:0] e,
                                   input logic t, input logic [15:0] w0,
                                   input logic [15:0] w1, input logic [15:0] w2,
                                   input logic [15:0] w3);
    dir_row_t r;
    r.item  = '{cmd: c, idx: i, v0: a, v1: b, v2: d, v3: e};
    r.typed = t;
    r.want  = {w3, w2, w1, w0};
    return r;
  endfunction

  function automatic logic [20:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 21'($urandom_range(0, 5000));
      4, 5:       return 21'($urandom_range(0, 20'hFFFFF));
      6:          return {1'b1, 20'($urandom)};
      7: begin
        case ($urandom_range(0, 6))
          0:       return 21'd0;
          1:       return 21'd4095;
          2:       return 21'd4096;
          3:       return 21'd4097;
          4:       return 21'h0FFFFF;
          5:       return 21'h100000;
          default: return 21'h1FFFFF;
        endcase
      end
      default:    return 21'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic mix_item_t random_item();
    mix_item_t it;
    it.cmd = ($urandom_range(0, 1) == 1) ? CMD_SET_ALL : CMD_SET_ONE;
    it.idx = 2'($urandom_range(0, 3));
    it.v0  = pick_value();
    it.v1  = pick_value();
    it.v2  = pick_value();
    it.v3  = pick_value();
    return it;
  endfunction

  // Returns at the edge where the input transfer takes place.
  task automatic send_item(input mix_item_t it);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.v3, it.v2, it.v1, it.v0, it.idx};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic expect_pulses(input mix_item_t it, input logic typed,
                               input logic [3:0][15:0] want, output int n);
    pulse_rec_t [3:0] recs;
    n = mix_throttles(it, recs);
    items_taken++;
    if (it.cmd == CMD_SET_ALL) set_all_count++;
    if (n == 0) ignored_count++;
    for (int k = 0; k < n; k++) begin
      if (typed) recs[k].ticks = want[k];
      pending_pulses.push_back(recs[k]);
    end
  endtask

  // A negative set_one leaves no result, so wait out the longest item as well.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_pulse_regs(input logic [15:0] at_zero, input logic [15:0] at_full);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_PULSE_ZERO;
    cfg_data_i  <= at_zero;
    do @(posedge clk_i); while (!cfg_ready_o);
    ticks_at_zero = at_zero;
    cfg_index_i <= REG_PULSE_FULL;
    cfg_data_i  <= at_full;
    do @(posedge clk_i); while (!cfg_ready_o);
    ticks_at_full = at_full;
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  always @(posedge clk_i) begin : pulse_monitor
    pulse_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_pulses.size() == 0) begin
        if (bad_results < 10) begin
          $display("cycle %0d: unexpected transfer motor %0d ticks %0d last %0d",
                   cycle_count, m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tlast);
        end
        bad_results++;
      end else begin
        want = pending_pulses.pop_front();
        if (m_axis_tdata[1:0] !== want.motor || m_axis_tdata[17:2] !== want.ticks ||
            m_axis_tlast !== want.last) begin
          if (bad_results < 10) begin
            $display("cycle %0d: expected motor %0d ticks %0d last %0d, got %0d %0d %0d",
                     cycle_count, want.motor, want.ticks, want.last,
                     m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tlast);
          end
          bad_results++;
        end
      end
    end
  end

  initial begin : rx_pattern
    int mode;
    int span;
    int k;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      for (k = 0; k < span; k++) begin
        @(posedge clk_i);
        if (rx_hold_req) begin
          m_axis_tready <= 1'b0;
          repeat (RX_HOLD_CYCLES) @(posedge clk_i);
          rx_hold_req = 1'b0;
        end else begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= (k % 4 == 3);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_throttle_normalizing_pwm_mixer: FAIL");
    $finish;
  end

  initial begin : stimulus
    int n;
    int done;
    mix_item_t it;
    foreach (throttle_q12[m]) begin
      throttle_q12[m] = '0;
      scaled_q12[m]   = '0;
    end
    ticks_at_zero = PULSE_ZERO_RST;
    ticks_at_full = PULSE_FULL_RST;

    dir_rows[0]  = row(CMD_SET_ONE, 2'd0, 21'd0, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd36000, 16'd0, 16'd0, 16'd0);
    dir_rows[1]  = row(CMD_SET_ONE, 2'd1, 21'd4096, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd14000, 16'd0, 16'd0, 16'd0);
    dir_rows[2]  = row(CMD_SET_ONE, 2'd2, 21'h1FFFFF, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
    dir_rows[3]  = row(CMD_SET_ONE, 2'd3, 21'h100000, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
    dir_rows[4]  = row(CMD_SET_ONE, 2'd2, 21'd2048, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd25000, 16'd0, 16'd0, 16'd0);
    dir_rows[5]  = row(CMD_SET_ALL, 2'd0, 21'd0, 21'd4096, 21'd2048, 21'd1024,
                       1'b1, 16'd36000, 16'd14000, 16'd25000, 16'd30500);
    dir_rows[6]  = row(CMD_SET_ALL, 2'd3, 21'd8192, 21'd4096, 21'd2048, 21'd0,
                       1'b1, 16'd14000, 16'd25000, 16'd30500, 16'd36000);
    // All four values negative: throttles stay, yet every motor is reported.
    dir_rows[7]  = row(CMD_SET_ALL, 2'd1, 21'h1FFFFF, 21'h1FF000, 21'h100000, 21'h1FFFF0,
                       1'b1, 16'd14000, 16'd25000, 16'd30500, 16'd36000);
    dir_rows[8]  = row(CMD_SET_ALL, 2'd2, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF,
                       1'b1, 16'd14000, 16'd14000, 16'd14000, 16'd14000);
    dir_rows[9]  = row(CMD_SET_ONE, 2'd0, 21'd0, 21'h1FFFFF, 21'h0AAAAA, 21'h155555,
                       1'b1, 16'd36000, 16'd0, 16'd0, 16'd0);
    dir_rows[10] = row(CMD_SET_ONE, 2'd3, 21'd1, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd36000, 16'd0, 16'd0, 16'd0);
    dir_rows[11] = row(CMD_SET_ALL, 2'd0, 21'd4097, 21'd4096, 21'd4095, 21'd1,
                       1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    dir_rows[12] = row(CMD_SET_ALL, 2'd3, 21'd1, 21'd2, 21'd3, 21'd4,
                       1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    dir_rows[13] = row(CMD_SET_ONE, 2'd1, 21'h080000, 21'd0, 21'd0, 21'd0,
                       1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    dir_rows[14] = row(CMD_SET_ONE, 2'd2, 21'h055555, 21'h1AAAAA, 21'h0FFFFF, 21'h100000,
                       1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    dir_rows[15] = row(CMD_SET_ALL, 2'd1, 21'd0, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd36000, 16'd36000, 16'd36000, 16'd36000);
    dir_rows[16] = row(CMD_SET_ONE, 2'd3, 21'd4096, 21'd0, 21'd0, 21'd0,
                       1'b1, 16'd14000, 16'd0, 16'd0, 16'd0);
    dir_rows[17] = row(CMD_SET_ALL, 2'd2, 21'h0AAAAA, 21'h155555, 21'h0FFFFF, 21'd4096,
                       1'b0, 16'd0, 16'd0, 16'd0, 16'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].item);
      expect_pulses(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want, n);
    end
    settle();

    zero_set[5] = 16'($urandom);
    full_set[5] = 16'($urandom);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) load_pulse_regs(zero_set[ph], full_set[ph]);
      // Stall the output for a long stretch while items keep coming.
      if (ph == 2) rx_hold_req = 1'b1;
      done = 0;
      while (done < PHASE_ITEMS) begin
        it = random_item();
        send_item(it);
        expect_pulses(it, 1'b0, '0, n);
        if (n != 0) done++;
      end
      settle();
    end

    $display("Covered %0d accepted items (%0d set_all, %0d without results), %0d pulse widths.",
             items_taken, set_all_count, ignored_count, results_seen);
    $display("Pulse registers reloaded %0d times including both range ends; %0d mismatches.",
             settings_loaded, bad_results);
    if (bad_results == 0 && pending_pulses.size() == 0) begin
      $display("tb_throttle_normalizing_pwm_mixer: PASS");
    end else begin
      $display("tb_throttle_normalizing_pwm_mixer: FAIL");
    end
    $finish;
  end

endmodule
